### sv/pdtp_pkg.sv
// package: shared types and constants for the pc delta table prefetcher
package pdtp_pkg;

   localparam int PC_W     = 48;
   localparam int LINE_W   = 42;
   localparam int DELTA_W  = 48;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MON_RD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MON_WR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_TH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_TH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LSHIFT   = 3'd6;

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;

   typedef enum logic [2:0] {
      RES_PREFETCH = 3'd0,
      RES_NONE     = 3'd1,
      RES_STORED   = 3'd2,
      RES_FILTERED = 3'd3,
      RES_FULL     = 3'd4
   } res_kind_type;

   typedef struct packed {
      logic              opcode;
      logic [PC_W-1:0]   pc;
      logic [LINE_W-1:0] line_addr;
      logic [1:0]        req_kind;
      logic              speculative;
      logic [3:0]        source_id;
      logic signed [DELTA_W-1:0] byte_delta;
      logic [15:0]       confidence;
      logic [15:0]       probability;
   } req_type;

   typedef struct packed {
      logic [2:0]        result_kind;
      logic [LINE_W-1:0] prefetch_line;
      logic [3:0]        dest_id;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic        mon_rd;
      logic        mon_wr;
      logic [15:0] conf_th;
      logic [15:0] prob_th;
      logic [3:0]  degree;
      logic        stride;
      logic [3:0]  lshift;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_LOAD_DEC,
      ST_READ,
      ST_READ_WAIT,
      ST_ACC_DEC,
      ST_EMIT,
      ST_STRIDE_EMIT,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic scan_clear;
      logic scan_step;
      logic load_decide;
      logic read_slot;
      logic read_latch;
      logic acc_decide;
      logic emit_step;
      logic stride_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_load;
      logic scan_done;
      logic read_done;
      logic no_fetch;
      logic emit_done;
      logic stride_go;
      logic stride_done;
   } stat_type;

endpackage

### sv/pdtp_ctrl.sv
// controller state machine sequencing table search, slot reads and result beats
module pdtp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pdtp_pkg::stat_type  stat,
   output logic                busy,
   output pdtp_pkg::cmd_type   cmd
);

   pdtp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdtp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         pdtp_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture    = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = pdtp_pkg::ST_SEARCH;
            end
         end
         pdtp_pkg::ST_SEARCH: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = pdtp_pkg::ST_READ;
            end
         end
         pdtp_pkg::ST_LOAD_DEC: begin
            cmd.load_decide = 1'b1;
            state_in        = pdtp_pkg::ST_DONE;
         end
         pdtp_pkg::ST_READ: begin
            cmd.read_slot = 1'b1;
            state_in      = pdtp_pkg::ST_READ_WAIT;
         end
         pdtp_pkg::ST_READ_WAIT: begin
            cmd.read_latch = 1'b1;
            if (stat.read_done) begin
               state_in = stat.is_load ? pdtp_pkg::ST_LOAD_DEC : pdtp_pkg::ST_ACC_DEC;
            end else begin
               state_in = pdtp_pkg::ST_READ;
            end
         end
         pdtp_pkg::ST_ACC_DEC: begin
            cmd.acc_decide = 1'b1;
            if (stat.no_fetch) begin
               state_in = pdtp_pkg::ST_DONE;
            end else begin
               state_in = pdtp_pkg::ST_EMIT;
            end
         end
         pdtp_pkg::ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (stat.emit_done) begin
               state_in = stat.stride_go ? pdtp_pkg::ST_STRIDE_EMIT : pdtp_pkg::ST_DONE;
            end
         end
         pdtp_pkg::ST_STRIDE_EMIT: begin
            cmd.stride_step = 1'b1;
            if (stat.stride_done) begin
               state_in = pdtp_pkg::ST_DONE;
            end
         end
         pdtp_pkg::ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = pdtp_pkg::ST_IDLE;
         end
         default: begin
            state_in = pdtp_pkg::ST_IDLE;
         end
      endcase
   end

   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> state_ff == pdtp_pkg::ST_IDLE) else $error("capture outside idle");
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == pdtp_pkg::ST_DONE |=> !busy) else $error("done did not return idle");
   a_wait_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == pdtp_pkg::ST_READ |=> state_ff == pdtp_pkg::ST_READ_WAIT)
      else $error("read without wait");

endmodule

### sv/pdtp_dp.sv
// datapath: table storage, delta sort, emit counters and result register
module pdtp_dp #(
   parameter int TABLE_ENTRIES    = 64,
   parameter int DELTAS_PER_ENTRY = 4,
   parameter int MAX_DEGREE       = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  pdtp_pkg::req_type   req,
   input  pdtp_pkg::cfg_type   cfg,
   input  pdtp_pkg::cmd_type   cmd,
   output pdtp_pkg::stat_type  stat,
   output logic                rsp_valid,
   output pdtp_pkg::rsp_type   rsp
);

   localparam int LW  = pdtp_pkg::LINE_W;
   localparam int PW  = pdtp_pkg::PC_W;
   localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SW  = (DELTAS_PER_ENTRY > 1) ? $clog2(DELTAS_PER_ENTRY) : 1;
   localparam int SLOTS = TABLE_ENTRIES * DELTAS_PER_ENTRY;
   localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ECW = $clog2(TABLE_ENTRIES + 1);
   localparam int SCW = $clog2(DELTAS_PER_ENTRY + 1);
   localparam int KW  = 4;

   // storage
   logic [TABLE_ENTRIES-1:0] ent_valid_ff;
   logic [PW-1:0]            ent_pc_mem [TABLE_ENTRIES];
   logic [LW-1:0]            hist_old_mem [TABLE_ENTRIES];
   logic [LW-1:0]            hist_new_mem [TABLE_ENTRIES];
   logic [LW-1:0]            slot_mem [SLOTS];
   logic [SLOTS-1:0]         slot_valid_ff;

   pdtp_pkg::req_type req_ff;

   // search
   logic [ECW-1:0] scan_ff;
   logic           hit_ff, free_ok_ff;
   logic [EW-1:0]  hit_idx_ff, free_idx_ff;
   logic [PW-1:0]  pc_rd_ff;
   logic           pc_rd_v_ff;
   logic [EW-1:0]  pc_rd_idx_ff;

   // slot read
   logic [SCW-1:0] rd_cnt_ff;
   logic [LW-1:0]  rd_data_ff;
   logic [LW-1:0]  h_old_ff, h_new_ff;
   logic [LW-1:0]  list_ff [DELTAS_PER_ENTRY];
   logic [SCW-1:0] cnt_ff;

   // emit
   logic [SCW-1:0] ei_ff;
   logic [KW-1:0]  k_ff;
   logic [LW-1:0]  acc_ff;
   logic [KW-1:0]  deg_ff;
   logic           stride_go_ff;
   logic [LW-1:0]  st_ff;

   logic           rsp_valid_ff;
   pdtp_pkg::rsp_type rsp_ff;

   logic [PW-1:0]  pc_m;
   logic [LW-1:0]  line_m;
   logic           monitored, trig;
   logic [EW-1:0]  ent_sel;
   logic [AW-1:0]  slot_base;
   logic [KW-1:0]  deg_eff;
   logic [LW-1:0]  d_line;
   logic [63:0]    dsx;
   logic           dup, slot_free;
   logic [SW-1:0]  free_slot;
   logic           filtered;
   logic [LW-1:0]  st_calc;
   logic           st_found;

   assign pc_m   = req_ff.pc;
   assign line_m = req_ff.line_addr;
   assign monitored = (cfg.mon_rd && req_ff.req_kind == pdtp_pkg::KIND_READ) ||
                      (cfg.mon_wr && req_ff.req_kind == pdtp_pkg::KIND_WRITE);
   assign trig = !req_ff.speculative && monitored;
   assign ent_sel = hit_ff ? hit_idx_ff : free_idx_ff;
   assign slot_base = AW'(ent_sel) * AW'(DELTAS_PER_ENTRY);

   always_comb begin
      deg_eff = cfg.degree;
      if (deg_eff == '0) begin
         deg_eff = KW'(1);
      end
      if (deg_eff > KW'(MAX_DEGREE)) begin
         deg_eff = KW'(MAX_DEGREE);
      end
   end

   // arithmetic shift of the byte delta into lines
   assign dsx    = 64'($signed(req_ff.byte_delta)) >>> cfg.lshift;
   assign d_line = dsx[LW-1:0];
   assign filtered = (req_ff.confidence < cfg.conf_th) ||
                     (req_ff.probability < cfg.prob_th);

   always_comb begin
      dup       = 1'b0;
      slot_free = 1'b0;
      free_slot = '0;
      for (int s = DELTAS_PER_ENTRY - 1; s >= 0; s--) begin
         if (hit_ff && SCW'(s) < cnt_ff && list_ff[s] == d_line) begin
            dup = 1'b1;
         end
         if (!hit_ff || !slot_valid_ff[slot_base + AW'(s)]) begin
            slot_free = 1'b1;
            free_slot = SW'(s);
         end
      end
   end

   assign st_calc = h_new_ff - h_old_ff;
   always_comb begin
      st_found = 1'b0;
      for (int i = 0; i < DELTAS_PER_ENTRY; i++) begin
         if (SCW'(i) < cnt_ff && list_ff[i] == st_calc) begin
            st_found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
   end

   // table search, one entry per cycle, pc read registered
   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         scan_ff    <= '0;
         hit_ff     <= 1'b0;
         free_ok_ff <= 1'b0;
         pc_rd_v_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (scan_ff < ECW'(TABLE_ENTRIES)) begin
            pc_rd_ff     <= ent_pc_mem[scan_ff[EW-1:0]];
            pc_rd_idx_ff <= scan_ff[EW-1:0];
            pc_rd_v_ff   <= ent_valid_ff[scan_ff[EW-1:0]];
            if (!ent_valid_ff[scan_ff[EW-1:0]] && !free_ok_ff) begin
               free_ok_ff  <= 1'b1;
               free_idx_ff <= scan_ff[EW-1:0];
            end
            scan_ff <= scan_ff + 1'b1;
         end else begin
            pc_rd_v_ff <= 1'b0;
         end
         if (pc_rd_v_ff && pc_rd_ff == pc_m && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= pc_rd_idx_ff;
         end
      end
   end

   assign stat.scan_done = cmd.scan_step && scan_ff == ECW'(TABLE_ENTRIES) && !pc_rd_v_ff;
   assign stat.is_load   = req_ff.opcode == pdtp_pkg::OP_LOAD;

   // slot read for both load and access, insertion sort into list
   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         rd_cnt_ff <= '0;
         cnt_ff    <= '0;
      end else if (cmd.read_latch) begin
         rd_cnt_ff <= rd_cnt_ff + 1'b1;
         if (slot_valid_ff[slot_base + AW'(rd_cnt_ff)] && hit_ff) begin
            for (int j = 0; j < DELTAS_PER_ENTRY; j++) begin
               if (SCW'(j) < cnt_ff) begin
                  if (list_ff[j] > rd_data_ff) begin
                     list_ff[j] <= (j == 0) ? rd_data_ff :
                                  ((list_ff[j-1 < 0 ? 0 : j-1] > rd_data_ff) ?
                                   list_ff[j-1 < 0 ? 0 : j-1] : rd_data_ff);
                  end
               end else if (SCW'(j) == cnt_ff) begin
                  list_ff[j] <= (j > 0 && list_ff[j-1 < 0 ? 0 : j-1] > rd_data_ff) ?
                                list_ff[j-1 < 0 ? 0 : j-1] : rd_data_ff;
               end
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign stat.read_done = rd_cnt_ff == SCW'(DELTAS_PER_ENTRY - 1);
   assign stat.no_fetch  = !hit_ff || !trig;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.read_slot) begin
         rd_data_ff <= slot_mem[slot_base + AW'(rd_cnt_ff)];
         h_old_ff   <= hist_old_mem[hit_idx_ff];
         h_new_ff   <= hist_new_mem[hit_idx_ff];
      end
      if (cmd.load_decide && !filtered && (hit_ff || free_ok_ff) && !dup && slot_free) begin
         slot_mem[slot_base + AW'(free_slot)] <= d_line;
      end
      if (cmd.load_decide && !filtered && !hit_ff && free_ok_ff) begin
         ent_pc_mem[free_idx_ff] <= pc_m;
      end
      if ((cmd.load_decide && !filtered && !hit_ff && free_ok_ff) ||
          (cmd.finish && !stat.is_load && hit_ff && trig && cfg.stride && deg_ff > KW'(1))) begin
         hist_old_mem[ent_sel] <= cmd.finish ? h_new_ff : '0;
         hist_new_mem[ent_sel] <= cmd.finish ? line_m   : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff  <= '0;
         slot_valid_ff <= '0;
      end else if (cmd.load_decide && !filtered && (hit_ff || free_ok_ff)) begin
         if (!hit_ff) begin
            ent_valid_ff[free_idx_ff] <= 1'b1;
            for (int s = 0; s < DELTAS_PER_ENTRY; s++) begin
               slot_valid_ff[slot_base + AW'(s)] <= (SW'(s) == free_slot);
            end
         end else if (!dup && slot_free) begin
            slot_valid_ff[slot_base + AW'(free_slot)] <= 1'b1;
         end
      end
   end

   // emit sequencing
   always_ff @(posedge clock) begin
      if (cmd.acc_decide) begin
         ei_ff        <= '0;
         k_ff         <= KW'(1);
         acc_ff       <= line_m + list_ff[0];
         deg_ff       <= deg_eff;
         st_ff        <= st_calc;
         stride_go_ff <= cfg.stride && deg_eff > KW'(1) && st_found &&
                         st_calc == (line_m - h_new_ff);
      end else if (cmd.emit_step) begin
         if (cfg.stride || k_ff >= deg_ff) begin
            ei_ff  <= ei_ff + 1'b1;
            k_ff   <= KW'(1);
            acc_ff <= stat.emit_done ? line_m + (st_ff << 1) :
                      line_m + list_ff[(ei_ff + 1'b1) >= SCW'(DELTAS_PER_ENTRY) ?
                      '0 : SW'(ei_ff + 1'b1)];
         end else begin
            k_ff   <= k_ff + 1'b1;
            acc_ff <= acc_ff + list_ff[SW'(ei_ff)];
         end
      end else if (cmd.stride_step) begin
         k_ff   <= k_ff + 1'b1;
         acc_ff <= acc_ff + st_ff;
      end
   end

   logic emit_last_one;
   assign emit_last_one = (ei_ff + 1'b1 == cnt_ff) && (cfg.stride || k_ff >= deg_ff);
   assign stat.emit_done   = cnt_ff == '0 || emit_last_one;
   assign stat.stride_go   = stride_go_ff;
   assign stat.stride_done = k_ff + 1'b1 >= deg_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_decide) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff.prefetch_line <= '0;
         rsp_ff.dest_id <= '0;
         rsp_ff.last <= 1'b1;
         if (filtered) begin
            rsp_ff.result_kind <= pdtp_pkg::RES_FILTERED;
         end else if ((!hit_ff && !free_ok_ff) || (!dup && !slot_free)) begin
            rsp_ff.result_kind <= pdtp_pkg::RES_FULL;
         end else begin
            rsp_ff.result_kind <= pdtp_pkg::RES_STORED;
         end
      end else if (cmd.acc_decide && (stat.no_fetch || cnt_ff == '0)) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff.result_kind   <= pdtp_pkg::RES_NONE;
         rsp_ff.prefetch_line <= '0;
         rsp_ff.dest_id       <= req_ff.source_id;
         rsp_ff.last          <= 1'b1;
      end else if ((cmd.emit_step && cnt_ff != '0) || cmd.stride_step) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff.result_kind   <= pdtp_pkg::RES_PREFETCH;
         rsp_ff.prefetch_line <= acc_ff;
         rsp_ff.dest_id       <= req_ff.source_id;
         rsp_ff.last          <= cmd.stride_step ? stat.stride_done :
                                 (stat.emit_done && !stride_go_ff);
      end else begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_decide && hit_ff |-> ent_valid_ff[hit_idx_ff]) else $error("hit on empty entry");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SCW'(DELTAS_PER_ENTRY)) else $error("delta count overflow");
   a_one_load_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.load_decide |=> rsp_valid && rsp.last) else $error("load gave no final beat");

endmodule

### sv/pc_delta_table_prefetcher.sv
// PC-indexed delta table prefetcher: one item at a time, start is taken only while busy is
// low and busy stays high until the item's last result beat is out. Every item searches
// the table serially, one entry per cycle, then reads its entry's delta slots one at a
// time, each through a read state and a wait state. A row load then passes through a
// decision state and a closing state that carries its single beat. An access passes
// through a decision state, emits its prefetch beats one per cycle (deltas times degree,
// or one per delta plus degree-1 stride beats in stride mode when the stride matches) and
// ends in a closing state; the next start is taken in the cycle after that. Result beats
// carry rsp_valid for one cycle each and cannot be stalled by the receiver.
module pc_delta_table_prefetcher #(
   parameter int TABLE_ENTRIES    = 64,
   parameter int DELTAS_PER_ENTRY = 4,
   parameter int MAX_DEGREE       = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  pdtp_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output pdtp_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [pdtp_pkg::CSR_IDX_W-1:0]        csr_idx,
   input  logic [pdtp_pkg::CSR_DAT_W-1:0]        csr_wdata
);

   pdtp_pkg::cfg_type  cfg_ff;
   pdtp_pkg::cmd_type  cmd;
   pdtp_pkg::stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mon_rd  <= 1'b1;
         cfg_ff.mon_wr  <= 1'b0;
         cfg_ff.conf_th <= '0;
         cfg_ff.prob_th <= '0;
         cfg_ff.degree  <= 4'd1;
         cfg_ff.stride  <= 1'b0;
         cfg_ff.lshift  <= 4'd6;
      end else if (csr_we) begin
         case (csr_idx)
            pdtp_pkg::CSR_MON_RD:  cfg_ff.mon_rd  <= csr_wdata[0];
            pdtp_pkg::CSR_MON_WR:  cfg_ff.mon_wr  <= csr_wdata[0];
            pdtp_pkg::CSR_CONF_TH: cfg_ff.conf_th <= csr_wdata;
            pdtp_pkg::CSR_PROB_TH: cfg_ff.prob_th <= csr_wdata;
            pdtp_pkg::CSR_DEGREE:  cfg_ff.degree  <= csr_wdata[3:0];
            pdtp_pkg::CSR_STRIDE:  cfg_ff.stride  <= csr_wdata[0];
            pdtp_pkg::CSR_LSHIFT:  cfg_ff.lshift  <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   pdtp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   pdtp_dp #(
      .TABLE_ENTRIES    (TABLE_ENTRIES),
      .DELTAS_PER_ENTRY (DELTAS_PER_ENTRY),
      .MAX_DEGREE       (MAX_DEGREE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

### dv/testbench.sv
// testbench for the pc delta table prefetcher: directed and random beats checked by a scoreboard
`timescale 1ns / 100ps

module testbench;

   localparam int LW          = pdtp_pkg::LINE_W;
   localparam int PW          = pdtp_pkg::PC_W;
   localparam int DW          = pdtp_pkg::DELTA_W;
   localparam int IW          = pdtp_pkg::CSR_IDX_W;
   localparam int VW          = pdtp_pkg::CSR_DAT_W;
   localparam int NUM_ENTRIES = 64;
   localparam int SLOTS_PER   = 4;
   localparam int DEG_MAX     = 8;
   localparam int IDLE_LIMIT  = 1000;
   localparam logic [LW-1:0] LINE_ALL = '1;

   class prefetch_scoreboard;
      bit                     ent_valid [NUM_ENTRIES];
      logic [PW-1:0]          ent_pc    [NUM_ENTRIES];
      logic [LW-1:0]          slot_delta[NUM_ENTRIES*SLOTS_PER];
      bit                     slot_valid[NUM_ENTRIES*SLOTS_PER];
      logic [LW-1:0]          hist_old  [NUM_ENTRIES];
      logic [LW-1:0]          hist_new  [NUM_ENTRIES];
      pdtp_pkg::cfg_type      cfg;
      pdtp_pkg::rsp_type      pending_beats[$];
      int                     errors;

      function new();
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            ent_valid[i] = 0;
            hist_old[i] = '0;
            hist_new[i] = '0;
         end
         for (int i = 0; i < NUM_ENTRIES*SLOTS_PER; i++) slot_valid[i] = 0;
         cfg = '0;
         cfg.mon_rd = 1'b1;
         cfg.degree = 4'd1;
         cfg.lshift = 4'd6;
         errors = 0;
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void write_reg(logic [IW-1:0] idx, logic [VW-1:0] val);
         case (idx)
            pdtp_pkg::CSR_MON_RD:  cfg.mon_rd = val[0];
            pdtp_pkg::CSR_MON_WR:  cfg.mon_wr = val[0];
            pdtp_pkg::CSR_CONF_TH: cfg.conf_th = val;
            pdtp_pkg::CSR_PROB_TH: cfg.prob_th = val;
            pdtp_pkg::CSR_DEGREE:  cfg.degree = val[3:0];
            pdtp_pkg::CSR_STRIDE:  cfg.stride = val[0];
            pdtp_pkg::CSR_LSHIFT:  cfg.lshift = val[3:0];
            default: ;
         endcase
      endfunction

      function int lookup(logic [PW-1:0] pc);
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (ent_valid[i] && ent_pc[i] == pc) return i;
         return -1;
      endfunction

      function void push(pdtp_pkg::res_kind_type k, logic [LW-1:0] line, logic [3:0] dest);
         pdtp_pkg::rsp_type b;
         b.result_kind = k;
         b.prefetch_line = line;
         b.dest_id = dest;
         b.last = 1'b0;
         pending_beats.push_back(b);
      endfunction

      function pdtp_pkg::res_kind_type store_row(pdtp_pkg::req_type r);
         logic signed [DW-1:0] shifted;
         logic [LW-1:0] d;
         int e, base;
         if (r.confidence < cfg.conf_th || r.probability < cfg.prob_th)
            return pdtp_pkg::RES_FILTERED;
         shifted = r.byte_delta >>> cfg.lshift;
         d = shifted[LW-1:0];
         e = lookup(r.pc);
         if (e < 0) begin
            for (e = 0; e < NUM_ENTRIES; e++) if (!ent_valid[e]) break;
            if (e >= NUM_ENTRIES) return pdtp_pkg::RES_FULL;
            ent_valid[e] = 1;
            ent_pc[e] = r.pc;
            hist_old[e] = '0;
            hist_new[e] = '0;
            for (int s = 0; s < SLOTS_PER; s++) slot_valid[e*SLOTS_PER+s] = 0;
         end
         base = e * SLOTS_PER;
         for (int s = 0; s < SLOTS_PER; s++)
            if (slot_valid[base+s] && slot_delta[base+s] == d) return pdtp_pkg::RES_STORED;
         for (int s = 0; s < SLOTS_PER; s++)
            if (!slot_valid[base+s]) begin
               slot_valid[base+s] = 1;
               slot_delta[base+s] = d;
               return pdtp_pkg::RES_STORED;
            end
         return pdtp_pkg::RES_FULL;
      endfunction

      function void predict_access(pdtp_pkg::req_type r);
         logic [LW-1:0] lst[SLOTS_PER];
         logic [LW-1:0] a, st, tmp;
         int e, cnt, n, deg, base;
         bit mon, found;
         mon = (cfg.mon_rd && r.req_kind == pdtp_pkg::KIND_READ) ||
               (cfg.mon_wr && r.req_kind == pdtp_pkg::KIND_WRITE);
         e = (!r.speculative && mon) ? lookup(r.pc) : -1;
         if (e < 0) begin
            push(pdtp_pkg::RES_NONE, '0, r.source_id);
            return;
         end
         deg = (cfg.degree == 0) ? 1 : (cfg.degree > DEG_MAX ? DEG_MAX : int'(cfg.degree));
         base = e * SLOTS_PER;
         cnt = 0;
         n = 0;
         for (int s = 0; s < SLOTS_PER; s++)
            if (slot_valid[base+s]) lst[cnt++] = slot_delta[base+s];
         for (int i = 0; i < cnt; i++)
            for (int j = 0; j + 1 < cnt - i; j++)
               if (lst[j] > lst[j+1]) begin
                  tmp = lst[j];
                  lst[j] = lst[j+1];
                  lst[j+1] = tmp;
               end
         for (int i = 0; i < cnt; i++) begin
            a = r.line_addr + lst[i];
            push(pdtp_pkg::RES_PREFETCH, a, r.source_id);
            n++;
            if (!cfg.stride)
               for (int k = 1; k < deg; k++) begin
                  a = a + lst[i];
                  push(pdtp_pkg::RES_PREFETCH, a, r.source_id);
                  n++;
               end
         end
         if (cfg.stride && deg > 1) begin
            st = hist_new[e] - hist_old[e];
            found = 0;
            for (int i = 0; i < cnt; i++) if (lst[i] == st) found = 1;
            tmp = r.line_addr - hist_new[e];
            if (found && st == tmp) begin
               a = r.line_addr + st + st;
               for (int k = 1; k < deg; k++) begin
                  push(pdtp_pkg::RES_PREFETCH, a, r.source_id);
                  n++;
                  a = a + st;
               end
            end
            hist_old[e] = hist_new[e];
            hist_new[e] = r.line_addr;
         end
         if (n == 0) push(pdtp_pkg::RES_NONE, '0, r.source_id);
      endfunction

      function void note_request(pdtp_pkg::req_type r);
         if (r.opcode == pdtp_pkg::OP_LOAD) push(store_row(r), '0, '0);
         else predict_access(r);
         pending_beats[$].last = 1'b1;
      endfunction

      task check_result(pdtp_pkg::rsp_type got);
         pdtp_pkg::rsp_type want;
         if (pending_beats.size() == 0) begin
            report($sformatf("unexpected beat %h", got));
            return;
         end
         want = pending_beats.pop_front();
         if (got.result_kind !== want.result_kind)
            report($sformatf("kind %0d, want %0d", got.result_kind, want.result_kind));
         if (got.prefetch_line !== want.prefetch_line)
            report($sformatf("line %h, want %h", got.prefetch_line, want.prefetch_line));
         if (got.dest_id !== want.dest_id)
            report($sformatf("dest %0d, want %0d", got.dest_id, want.dest_id));
         if (got.last !== want.last)
            report($sformatf("last %0d, want %0d", got.last, want.last));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   pdtp_pkg::req_type    req_data;
   logic                 rsp_valid;
   pdtp_pkg::rsp_type    rsp_data;
   logic                 csr_we;
   logic [IW-1:0]        csr_idx;
   logic [VW-1:0]        csr_wdata;

   prefetch_scoreboard sb;
   int                 idle_cycles = 0;
   bit                 burst;
   logic [PW-1:0]      pc_pool[8];

   pc_delta_table_prefetcher dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_data);
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   function int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (burst || p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(pdtp_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [IW-1:0] idx, logic [VW-1:0] val);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic pdtp_pkg::req_type row(logic [PW-1:0] pc, logic signed [DW-1:0] bd,
                                             logic [15:0] conf, logic [15:0] prob);
      pdtp_pkg::req_type r;
      r = '0;
      r.opcode = pdtp_pkg::OP_LOAD;
      r.pc = pc;
      r.byte_delta = bd;
      r.confidence = conf;
      r.probability = prob;
      r.source_id = 4'($urandom);
      r.line_addr = LW'({$urandom, $urandom});
      return r;
   endfunction

   function automatic pdtp_pkg::req_type acc(logic [PW-1:0] pc, logic [LW-1:0] line,
                                             logic [1:0] kind, logic spec);
      pdtp_pkg::req_type r;
      r = '0;
      r.opcode = pdtp_pkg::OP_ACCESS;
      r.pc = pc;
      r.line_addr = line;
      r.req_kind = kind;
      r.speculative = spec;
      r.source_id = 4'($urandom);
      r.byte_delta = DW'({$urandom, $urandom});
      r.confidence = 16'($urandom);
      r.probability = 16'($urandom);
      return r;
   endfunction

   function automatic logic [PW-1:0] any_pc();
      return ($urandom_range(0, 99) < 85) ? pc_pool[$urandom_range(0, 7)]
                                          : PW'({$urandom, $urandom});
   endfunction

   task automatic random_item();
      logic signed [DW-1:0] bd;
      logic [15:0] conf, prob;
      if ($urandom_range(0, 99) < 35) begin
         if ($urandom_range(0, 3) == 0) bd = DW'({$urandom, $urandom});
         else bd = DW'(int'($urandom_range(0, 32)) - 16) <<< sb.cfg.lshift;
         conf = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                16'($urandom_range(sb.cfg.conf_th, 16'hffff));
         prob = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                16'($urandom_range(sb.cfg.prob_th, 16'hffff));
         send(row(any_pc(), bd, conf, prob));
      end else begin
         send(acc(any_pc(), LW'({$urandom, $urandom}),
                  ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) :
                                               2'($urandom_range(2, 3)),
                  $urandom_range(0, 9) == 0));
      end
   endtask

   task automatic stride_run();
      logic [PW-1:0] pc;
      logic [LW-1:0] base, s;
      int sv, len;
      pc = pc_pool[$urandom_range(0, 7)];
      sv = int'($urandom_range(0, 20)) - 10;
      s = LW'(sv);
      base = LW'({$urandom, $urandom});
      len = $urandom_range(3, 5);
      send(row(pc, DW'(sv) <<< sb.cfg.lshift, 16'hffff, 16'hffff));
      for (int i = 0; i < len; i++) begin
         send(acc(pc, base, sb.cfg.mon_rd ? pdtp_pkg::KIND_READ : pdtp_pkg::KIND_WRITE, 1'b0));
         base = base + (($urandom_range(0, 5) == 0) ? LW'(1) : s);
      end
   endtask

   task automatic set_all(logic mr, logic mw, logic [15:0] ct, logic [15:0] pt,
                          logic [3:0] dg, logic sm, logic [3:0] ls);
      wait_idle();
      write_reg(pdtp_pkg::CSR_MON_RD, VW'(mr));
      write_reg(pdtp_pkg::CSR_MON_WR, VW'(mw));
      write_reg(pdtp_pkg::CSR_CONF_TH, ct);
      write_reg(pdtp_pkg::CSR_PROB_TH, pt);
      write_reg(pdtp_pkg::CSR_DEGREE, VW'(dg));
      write_reg(pdtp_pkg::CSR_STRIDE, VW'(sm));
      write_reg(pdtp_pkg::CSR_LSHIFT, VW'(ls));
   endtask

   initial begin
      logic [3:0] dg, ls;
      logic [15:0] th;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      burst = 0;
      pc_pool[0] = '0;
      pc_pool[1] = '1;
      for (int i = 2; i < 8; i++) pc_pool[i] = PW'({$urandom, $urandom});
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, delta extremes, every access kind
      send(row(pc_pool[1], 48'sd64, 16'd0, 16'd0));
      send(row(pc_pool[1], -48'sd64, 16'd0, 16'd0));
      send(row(pc_pool[1], 48'sh7fff_ffff_ffff, 16'hffff, 16'hffff));
      send(row(pc_pool[1], 48'sh8000_0000_0000, 16'd0, 16'd0));
      send(row(pc_pool[1], 48'sd64, 16'd0, 16'd0));
      send(row(pc_pool[1], 48'sd128, 16'd0, 16'd0));
      send(acc(pc_pool[1], LINE_ALL, pdtp_pkg::KIND_READ, 1'b0));
      send(acc(pc_pool[1], '0, pdtp_pkg::KIND_READ, 1'b0));
      send(acc(pc_pool[1], '0, pdtp_pkg::KIND_WRITE, 1'b0));
      send(acc(pc_pool[1], '0, 2'd2, 1'b0));
      send(acc(pc_pool[1], '0, 2'd3, 1'b0));
      send(acc(pc_pool[1], '0, pdtp_pkg::KIND_READ, 1'b1));
      send(acc(pc_pool[0], '0, pdtp_pkg::KIND_READ, 1'b0));
      set_all(1'b1, 1'b1, 16'h8000, 16'h8000, 4'd8, 1'b0, 4'd0);
      send(row(pc_pool[0], -48'sd1, 16'h7fff, 16'hffff));
      send(row(pc_pool[0], -48'sd1, 16'hffff, 16'h7fff));
      send(row(pc_pool[0], -48'sd1, 16'h8000, 16'h8000));
      send(row(pc_pool[0], 48'sd3, 16'h8000, 16'h8000));
      send(acc(pc_pool[0], LINE_ALL, pdtp_pkg::KIND_WRITE, 1'b0));
      set_all(1'b1, 1'b1, 16'hffff, 16'hffff, 4'd15, 1'b1, 4'd15);
      send(row(pc_pool[0], 48'sh8000, 16'hffff, 16'hffff));
      send(acc(pc_pool[0], 42'd10, pdtp_pkg::KIND_READ, 1'b0));
      send(acc(pc_pool[0], 42'd11, pdtp_pkg::KIND_READ, 1'b0));
      send(acc(pc_pool[0], 42'd12, pdtp_pkg::KIND_READ, 1'b0));

      // random phases over a spread of settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: dg = 4'd0;
            1: dg = 4'd8;
            2: dg = 4'd15;
            default: dg = 4'($urandom_range(1, 8));
         endcase
         case (ph % 3)
            0: ls = 4'd0;
            1: ls = 4'd12;
            default: ls = 4'($urandom_range(0, 15));
         endcase
         th = (ph % 3 == 2) ? 16'($urandom) : '0;
         set_all($urandom_range(0, 3) != 0, 1'($urandom), th, th >> $urandom_range(0, 8), dg,
                 ph[0], ls);
         burst = (ph == 3);
         for (int i = 0; i < 4; i++) begin
            if (sb.cfg.stride && $urandom_range(0, 2) == 0) stride_run();
            else random_item();
         end
      end

      // fill the table with fresh pcs until it overflows
      set_all(1'b1, 1'b1, 16'd0, 16'd0, 4'd2, 1'b0, 4'd6);
      for (int i = 0; i < NUM_ENTRIES + 2; i++)
         send(row(PW'({$urandom, $urandom}), DW'(int'($urandom_range(0, 15))) <<< 6,
                  16'($urandom), 16'($urandom)));
      for (int i = 0; i < 10; i++) random_item();

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending_beats.size() == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

endmodule
